// ===== rtl/core/mmpd_pkg.sv =====
// shared types, widths and constants of the min/max peak decimator
`default_nettype none

package mmpd_pkg;

    localparam int INDEX_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SAMPLE_W    = 16;
    localparam int COLUMN_W    = 32;
    localparam int START_W     = 31;
    localparam int STEP_W      = 32;
    localparam int STEP_FRAC_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO  = 1'b1;

    localparam logic [START_W-1:0] START_INDEX_RESET = '0;
    localparam logic [STEP_W-1:0]  STEP_RATIO_RESET  = 32'h0001_0000;

    localparam logic signed [SAMPLE_W-1:0] SEED_MAX = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SEED_MIN = 16'sh7fff;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       first;
    } item_t;

    typedef struct packed {
        logic [START_W-1:0] start_index;
        logic [STEP_W-1:0]  step_ratio;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/min_max_peak_decimator.sv =====
// top level of the min/max peak decimator
`default_nettype none

// Min/max peak decimator: one signed 16-bit sample request is taken per cycle,
// and a result (column index, bucket max, bucket min) for the sample that
// closed the bucket passes through an input register and a result register.
// The rate of one sample per cycle is set by the combinational update
// of sample counter, bucket edge and running extremes. The input is held off
// only when a result waits on m_ready and the sample in the input register
// would close another bucket. Write the configuration registers while idle.
module min_max_peak_decimator #(
    parameter int INDEX_BITS    = mmpd_pkg::INDEX_BITS_DEF,
    parameter int FRACTION_BITS = mmpd_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [mmpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mmpd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [mmpd_pkg::SAMPLE_W-1:0] s_sample_value,
    input  wire logic                                 s_first,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [mmpd_pkg::COLUMN_W-1:0]             m_column_index,
    output logic signed [mmpd_pkg::SAMPLE_W-1:0]      m_peak_max,
    output logic signed [mmpd_pkg::SAMPLE_W-1:0]      m_peak_min
);
    import mmpd_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_ready;

    mmpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mmpd_in_stage u_in_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_first        (s_first),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item)
    );

    mmpd_core #(
        .INDEX_BITS    (INDEX_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_index (m_column_index),
        .m_peak_max     (m_peak_max),
        .m_peak_min     (m_peak_min)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mmpd_cfg.sv =====
// configuration registers: start index and step ratio
`default_nettype none

module mmpd_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mmpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mmpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output mmpd_pkg::cfg_t                       cfg
);
    import mmpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_INDEX: cfg_next.start_index = cfg_wdata[START_W-1:0];
                CFG_STEP_RATIO:  cfg_next.step_ratio  = cfg_wdata[STEP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_index <= START_INDEX_RESET;
            cfg_reg.step_ratio  <= STEP_RATIO_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mmpd_in_stage.sv =====
// input register stage for sample requests
`default_nettype none

module mmpd_in_stage (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [mmpd_pkg::SAMPLE_W-1:0]  s_sample_value,
    input  wire logic                                  s_first,
    output logic                                       item_valid,
    input  wire logic                                  item_ready,
    output mmpd_pkg::item_t                            item
);
    import mmpd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready = !valid_reg || item_ready;

    always_comb begin
        valid_next = s_ready ? s_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.sample_value <= s_sample_value;
            item_reg.first        <= s_first;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mmpd_core.sv =====
// bucket edge tracking, min/max folding and result register
`default_nettype none

module mmpd_core #(
    parameter int INDEX_BITS    = mmpd_pkg::INDEX_BITS_DEF,
    parameter int FRACTION_BITS = mmpd_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  mmpd_pkg::cfg_t                            cfg,
    input  wire logic                                 item_valid,
    output logic                                      item_ready,
    input  mmpd_pkg::item_t                           item,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [mmpd_pkg::COLUMN_W-1:0]             m_column_index,
    output logic signed [mmpd_pkg::SAMPLE_W-1:0]      m_peak_max,
    output logic signed [mmpd_pkg::SAMPLE_W-1:0]      m_peak_min
);
    import mmpd_pkg::*;

    localparam int IW = INDEX_BITS;
    localparam int FW = FRACTION_BITS;

    logic [IW-1:0]              cnt_reg, cnt_next;
    logic [IW-1:0]              edge_int_reg, edge_int_next;
    logic [FW-1:0]              edge_frac_reg, edge_frac_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic                       out_valid_reg, out_valid_next;

    logic [COLUMN_W-1:0]        col_reg;
    logic signed [SAMPLE_W-1:0] pmax_reg;
    logic signed [SAMPLE_W-1:0] pmin_reg;

    logic [IW-1:0]              start_trunc;
    logic [IW-1:0]              eff_cnt;
    logic [IW-1:0]              eff_int;
    logic [FW-1:0]              eff_frac;
    logic signed [SAMPLE_W-1:0] eff_max;
    logic signed [SAMPLE_W-1:0] eff_min;
    logic signed [SAMPLE_W-1:0] base_max;
    logic signed [SAMPLE_W-1:0] base_min;
    logic signed [SAMPLE_W-1:0] x;
    logic [FW+STEP_FRAC_W-1:0]  step_frac_ext;
    logic [FW-1:0]              step_frac;
    logic [FW:0]                sum_frac;
    logic [IW:0]                sum_int;
    logic                       close;
    logic                       take;

    assign start_trunc   = IW'(cfg.start_index);
    assign x             = item.sample_value;
    assign step_frac_ext = (FW + STEP_FRAC_W)'(cfg.step_ratio[STEP_FRAC_W-1:0]) << FW;
    assign step_frac     = step_frac_ext[FW+STEP_FRAC_W-1:STEP_FRAC_W];

    always_comb begin
        if (item.first) begin
            eff_cnt  = start_trunc;
            eff_int  = start_trunc;
            eff_frac = '0;
            eff_max  = SEED_MAX;
            eff_min  = SEED_MIN;
        end else begin
            eff_cnt  = cnt_reg;
            eff_int  = edge_int_reg;
            eff_frac = edge_frac_reg;
            eff_max  = max_reg;
            eff_min  = min_reg;
        end
    end

    assign sum_frac = {1'b0, eff_frac} + {1'b0, step_frac};
    assign sum_int  = {1'b0, eff_int}
                    + (IW + 1)'(cfg.step_ratio[STEP_W-1:STEP_FRAC_W])
                    + (IW + 1)'(sum_frac[FW]);
    assign close    = sum_int < {1'b0, eff_cnt};

    assign item_ready = !out_valid_reg || m_ready || !close;
    assign take       = item_valid && item_ready;

    always_comb begin
        cnt_next       = cnt_reg;
        edge_int_next  = edge_int_reg;
        edge_frac_next = edge_frac_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        base_max       = eff_max;
        base_min       = eff_min;
        if (close) begin
            base_max = SEED_MAX;
            base_min = SEED_MIN;
        end
        if (take) begin
            cnt_next = eff_cnt + IW'(1);
            if (close) begin
                edge_int_next  = sum_int[IW-1:0];
                edge_frac_next = sum_frac[FW-1:0];
            end else begin
                edge_int_next  = eff_int;
                edge_frac_next = eff_frac;
            end
            max_next = (x > base_max) ? x : base_max;
            min_next = (x < base_min) ? x : base_min;
        end
    end

    always_comb begin
        if (take && close) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            edge_int_reg  <= '0;
            edge_frac_reg <= '0;
            max_reg       <= SEED_MAX;
            min_reg       <= SEED_MIN;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            edge_int_reg  <= edge_int_next;
            edge_frac_reg <= edge_frac_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && close) begin
            col_reg  <= COLUMN_W'(eff_cnt);
            pmax_reg <= eff_max;
            pmin_reg <= eff_min;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_column_index = col_reg;
    assign m_peak_max     = pmax_reg;
    assign m_peak_min     = pmin_reg;

`ifndef ASSERT_OFF
    a_first_restarts_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item.first) |=> (cnt_reg == $past(start_trunc) + IW'(1)))
        else $error("counter not restarted from start index");

    a_max_covers_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (max_reg >= $past(x)))
        else $error("running max below last sample");

    a_min_covers_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (min_reg <= $past(x)))
        else $error("running min above last sample");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && take) |-> !close)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
